// ===== design/fpa_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; fpa_front, fpa_back and the top-level ALU import this package.
`timescale 1ns / 1ps
package fpa_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int CMD_DEPTH     = 4;
   localparam int RSP_DEPTH     = 64;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_GT   = 4'd4,
      OP_LT   = 4'd5,
      OP_GE   = 4'd6,
      OP_LE   = 4'd7,
      OP_EQ   = 4'd8,
      OP_NE   = 4'd9,
      OP_MIN  = 4'd10,
      OP_MAX  = 4'd11,
      OP_INC  = 4'd12,
      OP_DEC  = 4'd13,
      OP_FROM = 4'd14,
      OP_TO   = 4'd15
   } op_type;

   // One classified request as it waits between front and back.
   typedef struct packed {
      op_type             op;
      logic               is_mul;
      logic               is_div;
      logic signed [31:0] a;
      logic signed [31:0] b;
   } item_type;

   typedef struct packed {
      logic [31:0] result;
      logic        truth;
      logic        div_by_zero;
   } rsp_type;

endpackage

// ===== design/fpa_queue.sv =====
// Show-ahead queue: memory plus a registered output slot.
// Depends on nothing but its parameters; DEPTH must be a power of two.
`timescale 1ns / 1ps
module fpa_queue #(
   parameter int  DEPTH = 4,
   parameter type T     = logic [7:0]
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     push_data,
   output logic full,
   input  logic pop,
   output T     pop_data,
   output logic empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   T                mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     cnt_ff, cnt_in;
   logic            out_v_ff, out_v_in;
   T                out_ff;
   logic            wr, load;

   assign full  = (cnt_ff == (PW+1)'(DEPTH));
   assign empty = !out_v_ff;
   assign pop_data = out_ff;
   assign wr   = push && !full;
   // Refill the output slot whenever memory holds an item and the slot is free or being taken.
   assign load = (cnt_ff != '0) && (!out_v_ff || pop);

   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = load ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (PW+1)'(wr) - (PW+1)'(load);
      if (load) begin
         out_v_in = 1'b1;
      end else if (pop) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

// ===== design/fpa_front.sv =====
// Front end: takes requests, classifies the opcode and queues the item.
// Depends on fpa_pkg and fpa_queue.
`timescale 1ns / 1ps
module fpa_front
   import fpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [3:0]         req_cmd,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic               issue,
   output item_type           item,
   output logic               item_empty
);
   item_type cls;

   always_comb begin
      cls.op     = op_type'(req_cmd);
      cls.is_mul = (cls.op == OP_MUL);
      cls.is_div = (cls.op == OP_DIV);
      cls.a      = req_operand_a;
      cls.b      = req_operand_b;
   end

   fpa_queue #(.DEPTH(CMD_DEPTH), .T(item_type)) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cls),
      .full      (full),
      .pop       (issue),
      .pop_data  (item),
      .empty     (item_empty)
   );

endmodule

// ===== design/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module fpa_div #(
   parameter int DW    = 40,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [DW-1:0]    dividend,
   input  logic [31:0]      divisor,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [DW-1:0]    quotient,
   output logic [TAG_W-1:0] out_tag
);
   logic [31:0]      rem_ff [DW];
   logic [DW-1:0]    dq_ff  [DW];
   logic [31:0]      dv_ff  [DW];
   logic [TAG_W-1:0] tag_ff [DW];
   logic             v_ff   [DW];

   for (genvar k = 0; k < DW; k++) begin : g_stage
      logic [31:0]      rem_i;
      logic [DW-1:0]    dq_i;
      logic [31:0]      dv_i;
      logic [TAG_W-1:0] tag_i;
      logic             v_i;
      logic [32:0]      trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_i = '0;
         assign dq_i  = dividend;
         assign dv_i  = divisor;
         assign tag_i = in_tag;
         assign v_i   = in_valid;
      end else begin : g_next
         assign rem_i = rem_ff[k-1];
         assign dq_i  = dq_ff[k-1];
         assign dv_i  = dv_ff[k-1];
         assign tag_i = tag_ff[k-1];
         assign v_i   = v_ff[k-1];
      end

      // The dividend bits shift out at the top while quotient bits enter below.
      assign trial = {rem_i, dq_i[DW-1]};
      assign ge    = (trial >= {1'b0, dv_i});

      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? 32'(trial - {1'b0, dv_i}) : trial[31:0];
         dq_ff[k]  <= {dq_i[DW-2:0], ge};
         dv_ff[k]  <= dv_i;
         tag_ff[k] <= tag_i;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_i;
         end
      end
   end

   assign out_valid = v_ff[DW-1];
   assign quotient  = dq_ff[DW-1];
   assign out_tag   = tag_ff[DW-1];

endmodule

// ===== design/fpa_back.sv =====
// Back end: executes one item per cycle through a fixed-length pipeline.
// Depends on fpa_pkg and fpa_div.
`timescale 1ns / 1ps
module fpa_back
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     issue,
   input  item_type item,
   output logic     out_valid,
   output rsp_type  out_rsp
);
   localparam int DW    = 32 + FRAC_BITS;
   localparam int TAG_W = 36;

   // Stage 0: issued item.
   logic     v0_ff;
   item_type i0_ff;

   // Stage 1: product, early results, divider magnitudes.
   logic               v1_ff;
   logic signed [63:0] prod_ff;
   logic [31:0]        early_ff, early_in;
   logic               truth_ff, truth_in;
   logic               dz1_ff, mul1_ff, div1_ff, neg1_ff;
   logic [31:0]        amag_ff, bmag_ff;

   // Stage 2: merged result enters the divider.
   logic [31:0] res2;
   logic [TAG_W-1:0] tag2, tag_o;
   logic             v_o;
   logic [DW-1:0]    quo;
   logic [31:0]      q32, qs;
   logic [31:0]      res_o;
   logic             truth_o, dz_o, div_o, neg_o;

   logic signed [31:0] a, b, bias;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= issue;
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      i0_ff <= item;
   end

   assign a    = i0_ff.a;
   assign b    = i0_ff.b;
   // Truncation toward zero for to_int: bias negative values before the shift.
   assign bias = a[31] ? 32'((64'sd1 <<< FRAC_BITS) - 64'sd1) : 32'sd0;

   always_comb begin
      early_in = '0;
      truth_in = 1'b0;
      case (i0_ff.op)
         OP_ADD:  early_in = 32'(a + b);
         OP_SUB:  early_in = 32'(a - b);
         OP_GT:   truth_in = (a > b);
         OP_LT:   truth_in = (a < b);
         OP_GE:   truth_in = (a >= b);
         OP_LE:   truth_in = (a <= b);
         OP_EQ:   truth_in = (a == b);
         OP_NE:   truth_in = (a != b);
         OP_MIN:  early_in = (a < b) ? a : b;
         OP_MAX:  early_in = (a > b) ? a : b;
         OP_INC:  early_in = 32'(a + 32'sd1);
         OP_DEC:  early_in = 32'(a - 32'sd1);
         OP_FROM: early_in = a << FRAC_BITS;
         OP_TO:   early_in = 32'((a + bias) >>> FRAC_BITS);
         default: early_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff  <= 64'(a) * 64'(b);
      early_ff <= early_in;
      truth_ff <= truth_in;
      dz1_ff   <= i0_ff.is_div && (b == 32'sd0);
      mul1_ff  <= i0_ff.is_mul;
      div1_ff  <= i0_ff.is_div;
      neg1_ff  <= a[31] ^ b[31];
      amag_ff  <= a[31] ? 32'(-a) : a;
      bmag_ff  <= b[31] ? 32'(-b) : b;
   end

   assign res2 = mul1_ff ? prod_ff[FRAC_BITS+31:FRAC_BITS] : early_ff;
   assign tag2 = {res2, truth_ff, dz1_ff, div1_ff, neg1_ff};

   fpa_div #(.DW(DW), .TAG_W(TAG_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .dividend  ({amag_ff, {FRAC_BITS{1'b0}}}),
      .divisor   (bmag_ff),
      .in_tag    (tag2),
      .out_valid (v_o),
      .quotient  (quo),
      .out_tag   (tag_o)
   );

   assign {res_o, truth_o, dz_o, div_o, neg_o} = tag_o;
   assign q32 = quo[31:0];
   assign qs  = neg_o ? 32'(-q32) : q32;

   assign out_valid           = v_o;
   assign out_rsp.result      = (div_o && !dz_o) ? qs : res_o;
   assign out_rsp.truth       = truth_o;
   assign out_rsp.div_by_zero = dz_o;

endmodule

// ===== design/fixed_point_q24_8_alu.sv =====
// Q24.8 fixed-point ALU. From push to empty going low a request passes the
// request queue, the stage 0 and stage 1 registers ahead of the divider, one
// divider stage per quotient bit and the result queue, which all operations
// pass. Throughput is one request per cycle while results are popped.
// Synchronous active-high reset empties both queues and the pipeline.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [3:0]         req_cmd,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic               pop,
   output logic               empty,
   output logic signed [31:0] rsp_result,
   output logic               rsp_truth,
   output logic               rsp_div_by_zero
);
   localparam int OW = $clog2(RSP_DEPTH + 1);

   item_type      item;
   logic          item_empty, issue;
   logic          bk_valid;
   rsp_type       bk_rsp, rsp;
   logic          rsp_full;
   logic [OW-1:0] outst_ff, outst_in;
   logic          rsp_pop;

   // Requests in flight plus waiting results never exceed the result queue.
   assign issue   = !item_empty && (outst_ff < OW'(RSP_DEPTH));
   assign rsp_pop = pop && !empty;
   assign outst_in = outst_ff + OW'(issue) - OW'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   fpa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_cmd       (req_cmd),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .issue         (issue),
      .item          (item),
      .item_empty    (item_empty)
   );

   fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .item      (item),
      .out_valid (bk_valid),
      .out_rsp   (bk_rsp)
   );

   fpa_queue #(.DEPTH(RSP_DEPTH), .T(rsp_type)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (bk_valid),
      .push_data (bk_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp),
      .empty     (empty)
   );

   assign rsp_result      = rsp.result;
   assign rsp_truth       = rsp.truth;
   assign rsp_div_by_zero = rsp.div_by_zero;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      bk_valid |-> !rsp_full)
      else $error("result written into a full result queue");

   a_outst_bound: assert property (@(posedge clock) disable iff (reset)
      outst_ff <= OW'(RSP_DEPTH))
      else $error("outstanding count above result queue depth");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_div_by_zero) |-> (rsp_result == 32'sd0 && !rsp_truth))
      else $error("divide by zero with nonzero result");

   a_truth_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_truth) |-> (rsp_result == 32'sd0))
      else $error("comparison with nonzero result");

   a_empty_outst: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (outst_ff != '0))
      else $error("result shown with nothing outstanding");

endmodule
